[rtl/dlle_pkg.sv]
`default_nettype none

package dlle_pkg;

	// Default size of the node pool, sentinels included.
	localparam int POOL_SLOTS_DEF = 64;

	// Field widths of one command beat and one result beat.
	localparam int KIND_W = 3;
	localparam int POS_W  = 6;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;

	// Width used to compare slot numbers against the allocation counter.
	localparam int CMP_W = 8;

	// Fixed sentinel slots and the first slot handed out to a node.
	localparam int HEAD_SLOT  = 0;
	localparam int TAIL_SLOT  = 1;
	localparam int FIRST_FREE = 2;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [STAT_W-1:0] status_t;

	// Command codes.
	localparam kind_t KIND_FRONT  = 3'd0;
	localparam kind_t KIND_BACK   = 3'd1;
	localparam kind_t KIND_DELETE = 3'd2;
	localparam kind_t KIND_LEFT   = 3'd3;
	localparam kind_t KIND_RIGHT  = 3'd4;
	localparam kind_t KIND_DUMP   = 3'd5;

	// Status codes.
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_FULL  = 2'd1;
	localparam status_t STATUS_BAD   = 2'd2;
	localparam status_t STATUS_EMPTY = 2'd3;

endpackage

`default_nettype wire

[rtl/dlle_ram.sv]
`default_nettype none

module dlle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/doubly_linked_list_engine_core.sv]
// Doubly linked list engine. A command beat is taken when start is high and busy is low;
// every command except an unknown kind answers with result beats that appear on the result
// ports for exactly one cycle each, marked by result_valid, and must be taken as they come.
// Error answers (bad position, pool full) and the answer to a dump of an empty list come in the
// cycle after the command, with busy never raised, so a new command can follow at once.
// Insert at front, at back or right of a node reads the anchor node, writes the new node
// and then points its neighbors at it; insert left of a node must first fetch the node's
// left neighbor. A delete reads the node's links and then joins its two neighbors. A dump
// streams one value per cycle. These steps follow the chain of dependent reads through the
// node and link memories, each with a single read port and registered read data.
`default_nettype none

module doubly_linked_list_engine_core #(
	parameter int POOL_SLOTS = dlle_pkg::POOL_SLOTS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire dlle_pkg::kind_t                     kind,
	input  wire logic [dlle_pkg::POS_W-1:0]          position,
	input  wire logic signed [dlle_pkg::VAL_W-1:0]   value,
	output logic                                     result_valid,
	output logic signed [dlle_pkg::VAL_W-1:0]        item,
	output dlle_pkg::status_t                        status,
	output logic                                     has_item,
	output logic                                     is_last
);

	import dlle_pkg::*;

	localparam int SW     = $clog2(POOL_SLOTS);
	localparam int FW     = $clog2(POOL_SLOTS + 1);
	localparam int NW     = VAL_W + SW;
	localparam int LIVE_N = 2 ** SW;

	localparam logic [SW-1:0] HEAD_IDX = SW'(HEAD_SLOT);
	localparam logic [SW-1:0] TAIL_IDX = SW'(TAIL_SLOT);

	// Sequencer states.
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_RD_ANCH = 3'd1;
	localparam logic [2:0] S_RD_NODE = 3'd2;
	localparam logic [2:0] S_WR_LINK = 3'd3;
	localparam logic [2:0] S_DEL_RD  = 3'd4;
	localparam logic [2:0] S_DEL_WR  = 3'd5;
	localparam logic [2:0] S_DUMP    = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [FW-1:0]     nf_q;
	logic [LIVE_N-1:0] live_q;
	logic [SW-1:0]     head_next_q, tail_prev_q;
	logic [SW-1:0]     anchor_q, after_q, slot_q, pred_q, succ_q;
	logic [VAL_W-1:0]  val_q, aval_q;

	logic                     result_valid_q;
	logic signed [VAL_W-1:0]  item_q;
	status_t                  status_q;
	logic                     has_item_q, is_last_q;

	// Node memory holds {value, next link}; the link memory holds the previous link.
	logic          node_we, prev_we;
	logic [SW-1:0] node_waddr, node_raddr, prev_waddr, prev_raddr;
	logic [NW-1:0] node_wdata, node_rdata;
	logic [SW-1:0] prev_wdata, prev_rdata;

	logic [VAL_W-1:0] node_rd_value;
	logic [SW-1:0]    node_rd_next;

	logic [CMP_W-1:0] slot_cmp, nf_cmp;
	logic [SW-1:0]    slot_idx, new_idx, insert_after;
	logic             accept, slot_ok, full;

	logic                    emit, emit_has, emit_last;
	status_t                 emit_status;
	logic signed [VAL_W-1:0] emit_item;

	dlle_ram #(
		.WIDTH(NW),
		.DEPTH(POOL_SLOTS)
	) u_node_ram (
		.clk  (clk),
		.we   (node_we),
		.waddr(node_waddr),
		.wdata(node_wdata),
		.raddr(node_raddr),
		.rdata(node_rdata)
	);

	dlle_ram #(
		.WIDTH(SW),
		.DEPTH(POOL_SLOTS)
	) u_prev_ram (
		.clk  (clk),
		.we   (prev_we),
		.waddr(prev_waddr),
		.wdata(prev_wdata),
		.raddr(prev_raddr),
		.rdata(prev_rdata)
	);

	assign node_rd_value = node_rdata[NW-1:SW];
	assign node_rd_next  = node_rdata[SW-1:0];

	// Slot of the referenced node and the checks made before any command starts.
	assign slot_cmp = CMP_W'(position) + CMP_W'(1);
	assign nf_cmp   = CMP_W'(nf_q);
	assign slot_idx = slot_cmp[SW-1:0];
	assign new_idx  = nf_q[SW-1:0];
	assign slot_ok  = (slot_cmp >= CMP_W'(FIRST_FREE)) && (slot_cmp < nf_cmp) && live_q[slot_idx];
	assign full     = nf_cmp >= CMP_W'(POOL_SLOTS);
	assign busy     = state_q != S_IDLE;
	assign accept   = start && !busy;

	// The right neighbor of a new node: the head's link lives in a register.
	assign insert_after = (anchor_q == HEAD_IDX) ? head_next_q : node_rd_next;

	// Sequencer: memory addresses, write-backs and result beats.
	always_comb begin
		state_d     = state_q;
		node_we     = 1'b0;
		node_waddr  = new_idx;
		node_wdata  = {val_q, insert_after};
		node_raddr  = slot_idx;
		prev_we     = 1'b0;
		prev_waddr  = new_idx;
		prev_wdata  = anchor_q;
		prev_raddr  = slot_idx;
		emit        = 1'b0;
		emit_status = STATUS_OK;
		emit_item   = '0;
		emit_has    = 1'b0;
		emit_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (kind)
						KIND_FRONT: begin
							if (full) begin
								emit        = 1'b1;
								emit_status = STATUS_FULL;
							end else begin
								node_raddr = HEAD_IDX;
								state_d    = S_RD_NODE;
							end
						end
						KIND_BACK: begin
							if (full) begin
								emit        = 1'b1;
								emit_status = STATUS_FULL;
							end else begin
								node_raddr = tail_prev_q;
								state_d    = S_RD_NODE;
							end
						end
						KIND_LEFT: begin
							if (!slot_ok) begin
								emit        = 1'b1;
								emit_status = STATUS_BAD;
							end else if (full) begin
								emit        = 1'b1;
								emit_status = STATUS_FULL;
							end else begin
								prev_raddr = slot_idx;
								state_d    = S_RD_ANCH;
							end
						end
						KIND_RIGHT: begin
							if (!slot_ok) begin
								emit        = 1'b1;
								emit_status = STATUS_BAD;
							end else if (full) begin
								emit        = 1'b1;
								emit_status = STATUS_FULL;
							end else begin
								node_raddr = slot_idx;
								state_d    = S_RD_NODE;
							end
						end
						KIND_DELETE: begin
							if (!slot_ok) begin
								emit        = 1'b1;
								emit_status = STATUS_BAD;
							end else begin
								node_raddr = slot_idx;
								prev_raddr = slot_idx;
								state_d    = S_DEL_RD;
							end
						end
						KIND_DUMP: begin
							if (head_next_q == TAIL_IDX) begin
								emit        = 1'b1;
								emit_status = STATUS_EMPTY;
							end else begin
								node_raddr = head_next_q;
								state_d    = S_DUMP;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_RD_ANCH: begin
				node_raddr = prev_rdata;
				state_d    = S_RD_NODE;
			end
			S_RD_NODE: begin
				// Write the new node with both of its links.
				node_we    = 1'b1;
				node_waddr = new_idx;
				node_wdata = {val_q, insert_after};
				prev_we    = 1'b1;
				prev_waddr = new_idx;
				prev_wdata = anchor_q;
				state_d    = S_WR_LINK;
			end
			S_WR_LINK: begin
				// Point the neighbors at the new node.
				node_we    = anchor_q != HEAD_IDX;
				node_waddr = anchor_q;
				node_wdata = {aval_q, new_idx};
				prev_we    = after_q != TAIL_IDX;
				prev_waddr = after_q;
				prev_wdata = new_idx;
				emit       = 1'b1;
				state_d    = S_IDLE;
			end
			S_DEL_RD: begin
				node_raddr = prev_rdata;
				state_d    = S_DEL_WR;
			end
			S_DEL_WR: begin
				// Join the two neighbors of the removed node.
				node_we    = pred_q != HEAD_IDX;
				node_waddr = pred_q;
				node_wdata = {node_rd_value, succ_q};
				prev_we    = succ_q != TAIL_IDX;
				prev_waddr = succ_q;
				prev_wdata = pred_q;
				emit       = 1'b1;
				state_d    = S_IDLE;
			end
			S_DUMP: begin
				emit       = 1'b1;
				emit_item  = node_rd_value;
				emit_has   = 1'b1;
				emit_last  = node_rd_next == TAIL_IDX;
				node_raddr = node_rd_next;
				if (emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state: sequencer, allocation counter, live bits and sentinel links.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			nf_q           <= FW'(FIRST_FREE);
			live_q         <= '0;
			head_next_q    <= TAIL_IDX;
			tail_prev_q    <= HEAD_IDX;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= emit;
			if (state_q == S_WR_LINK) begin
				if (anchor_q == HEAD_IDX) begin
					head_next_q <= new_idx;
				end
				if (after_q == TAIL_IDX) begin
					tail_prev_q <= new_idx;
				end
				live_q[new_idx] <= 1'b1;
				nf_q            <= nf_q + FW'(1);
			end
			if (state_q == S_DEL_WR) begin
				if (pred_q == HEAD_IDX) begin
					head_next_q <= succ_q;
				end
				if (succ_q == TAIL_IDX) begin
					tail_prev_q <= pred_q;
				end
				live_q[slot_q] <= 1'b0;
			end
		end
	end

	// Working registers of the command in flight and the result beat.
	always_ff @(posedge clk) begin
		priority if (accept) begin
			slot_q <= slot_idx;
			val_q  <= value;
			if (kind == KIND_BACK) begin
				anchor_q <= tail_prev_q;
			end else if (kind == KIND_RIGHT) begin
				anchor_q <= slot_idx;
			end else begin
				anchor_q <= HEAD_IDX;
			end
		end else if (state_q == S_RD_ANCH) begin
			anchor_q <= prev_rdata;
		end else if (state_q == S_RD_NODE) begin
			after_q <= insert_after;
			aval_q  <= node_rd_value;
		end else if (state_q == S_DEL_RD) begin
			pred_q <= prev_rdata;
			succ_q <= node_rd_next;
		end else begin
			slot_q <= slot_q;
		end
		if (emit) begin
			item_q     <= emit_item;
			status_q   <= emit_status;
			has_item_q <= emit_has;
			is_last_q  <= emit_last;
		end
	end

	assign result_valid = result_valid_q;
	assign item         = item_q;
	assign status       = status_q;
	assign has_item     = has_item_q;
	assign is_last      = is_last_q;

	// The allocation counter never runs past the end of the pool.
	a_nf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nf_cmp <= CMP_W'(POOL_SLOTS))
		else $error("allocation counter beyond pool");

	// Sentinel slots are never marked as live nodes.
	a_sentinel_dead: assert property (@(posedge clk) disable iff (!arst_n)
		!live_q[HEAD_IDX] && !live_q[TAIL_IDX])
		else $error("sentinel slot marked live");

	// A dump streams without gaps until its last beat.
	a_dump_stream: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_last |=> result_valid && has_item)
		else $error("gap in dump stream");

	// A status-only beat carries a zero item and closes its command.
	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_item |-> item == '0 && is_last)
		else $error("malformed status beat");

	// A delete of a node that is not live is refused in the next cycle.
	a_bad_delete: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_DELETE && !slot_ok |=> result_valid && status == STATUS_BAD)
		else $error("bad delete not reported");

endmodule

`default_nettype wire
